// ===== hw/rtl/lmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared constants and types for the local maximum detector: register
// widths, register indexes and default sizes.
// ----------------------------------------------------------------------------
package lmd_pkg;

  // default sizes handed to the top level
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_PIXEL_BITS = 16;

  // register and field widths
  localparam int ROWS_W = 13;
  localparam int COLS_W = 8;
  localparam int ROW_W  = 12;
  localparam int CFG_W  = 13;

  // largest frame height
  localparam int ROWS_LIMIT = 4096;

  // register reset values
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(8);
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(8);

  // register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_ROWS = 1'b0,
    CFG_FRAME_COLS = 1'b1
  } cfg_index_t;

endpackage

// ===== hw/rtl/lmd_line_store.sv =====
// ----------------------------------------------------------------------------
// lmd_line_store
// Line store holding the upper and centre row of each column. One write
// port, two registered read ports, with write-to-read forwarding when a
// read address is written at the same edge.
// ----------------------------------------------------------------------------
module lmd_line_store #(
  parameter int DEPTH  = 128,
  parameter int DATA_W = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic [DATA_W-1:0] wdata_q;
  logic              fwd_a;
  logic              fwd_b;

  // storage array, write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a    <= mem[raddr_a];
    rd_b    <= mem[raddr_b];
    wdata_q <= wdata;
  end

  // note reads that collide with the write at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else begin
      fwd_a <= we && (raddr_a == waddr);
      fwd_b <= we && (raddr_b == waddr);
    end
  end

  // forwarded read data
  assign rdata_a = fwd_a ? wdata_q : rd_a;
  assign rdata_b = fwd_b ? wdata_q : rd_b;

endmodule

// ===== hw/rtl/local_maximum_detector_unit.sv =====
// ----------------------------------------------------------------------------
// local_maximum_detector_unit
// Four-neighbour strict local maximum detector over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on pixel/pixel_valid/pixel_stall in raster order, one word
//   per accepted cycle. A pixel is taken at an edge where pixel_valid is high
//   and pixel_stall is low. When the pixel below an interior centre arrives,
//   the centre is compared with its four neighbours; if it is strictly the
//   largest, one word (peak_value, peak_row, peak_col) is offered on the
//   peak channel, via the skid register if the output register is stalled.
//   Throughput is one pixel per cycle while pixel_stall is low: the line
//   store has two read ports, read each cycle at the column of the next pixel
//   and the one after, so every neighbour is on hand in the cycle it is taken.
//   A two-deep output stage (output register plus skid register) lets the
//   input keep flowing while a peak waits; pixel_stall rises only while the
//   skid register is occupied, that is after the receiver has stalled with
//   two peaks pending.
//   Frame size is set through cfg_we/cfg_index/cfg_data while idle.
//   Reset clears the row and column counters and restores an 8 by 8 frame;
//   there is no clearing pass, the line store fills as rows arrive.
// ----------------------------------------------------------------------------
module local_maximum_detector_unit #(
  parameter int MAX_WIDTH  = lmd_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = lmd_pkg::DEF_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  lmd_pkg::cfg_index_t          cfg_index,
  input  logic [lmd_pkg::CFG_W-1:0]    cfg_data,
  // pixel channel
  input  logic [PIXEL_BITS-1:0]        pixel,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  // peak channel
  output logic [PIXEL_BITS-1:0]        peak_value,
  output logic [lmd_pkg::ROW_W-1:0]    peak_row,
  output logic [$clog2(MAX_WIDTH)-1:0] peak_col,
  output logic                         peak_valid,
  input  logic                         peak_stall
);

  import lmd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CCW = CW + 1;
  localparam int EW  = 2 * PIXEL_BITS;

  // configuration registers
  logic [ROWS_W-1:0] frame_rows;
  logic [COLS_W-1:0] frame_cols;

  // position of the next pixel
  logic [ROW_W-1:0]  row_count;
  logic [CW-1:0]     col_count;
  logic [ROW_W-1:0]  row_count_next;
  logic [CW-1:0]     col_count_next;

  // centre of the previous column, i.e. the left neighbour
  logic [PIXEL_BITS-1:0] left;

  // skid register
  logic                  skid_valid;
  logic [PIXEL_BITS-1:0] skid_value;
  logic [ROW_W-1:0]      skid_row;
  logic [CW-1:0]         skid_col;

  logic [ROWS_W-1:0]     rows_eff;
  logic [CCW-1:0]        cols_eff;
  logic [ROWS_W-1:0]     row_inc;
  logic [CCW-1:0]        col_inc;
  logic [CCW-1:0]        col_plus2;
  logic                  last_col;
  logic                  last_row;
  logic                  interior;
  logic                  accept;
  logic                  hit;
  logic                  res_valid;
  logic                  out_free;

  logic [CW-1:0]         raddr_a;
  logic [CW-1:0]         raddr_b;
  logic [EW-1:0]         rdata_a;
  logic [EW-1:0]         rdata_b;
  logic [EW-1:0]         wdata;
  logic [PIXEL_BITS-1:0] centre;
  logic [PIXEL_BITS-1:0] upper;
  logic [PIXEL_BITS-1:0] right;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= ROWS_RESET;
      frame_cols <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_ROWS: frame_rows <= cfg_data;
        CFG_FRAME_COLS: frame_cols <= cfg_data[COLS_W-1:0];
        default:        frame_rows <= frame_rows;
      endcase
    end
  end

  // clamp frame size to its legal range
  always_comb begin
    if (frame_rows == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (frame_rows > ROWS_W'(ROWS_LIMIT)) begin
      rows_eff = ROWS_W'(ROWS_LIMIT);
    end else begin
      rows_eff = frame_rows;
    end
    if (frame_cols == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(frame_cols) > 32'(MAX_WIDTH)) begin
      cols_eff = CCW'(MAX_WIDTH);
    end else begin
      cols_eff = CCW'(frame_cols);
    end
  end

  // position decode
  assign accept    = pixel_valid && !pixel_stall;
  assign col_inc   = {1'b0, col_count} + CCW'(1);
  assign col_plus2 = {1'b0, col_count} + CCW'(2);
  assign row_inc   = {1'b0, row_count} + ROWS_W'(1);
  assign last_col  = col_inc >= cols_eff;
  assign last_row  = row_inc >= rows_eff;
  assign interior  = (row_count >= ROW_W'(2)) && (col_count != '0)
                     && (col_plus2 <= cols_eff);

  // counter advance
  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count;
    if (accept) begin
      if (last_col) begin
        col_count_next = '0;
        row_count_next = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_count_next = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // line store reads ahead at the next column and its right neighbour
  assign raddr_a = col_count_next;
  assign raddr_b = (32'(raddr_a) == MAX_WIDTH - 1) ? '0 : raddr_a + CW'(1);

  // shift the centre into the upper row and the pixel into the centre row
  assign wdata = {centre, pixel};

  lmd_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (EW)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .we      (accept),
    .waddr   (col_count),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign centre = rdata_a[PIXEL_BITS-1:0];
  assign upper  = rdata_a[EW-1:PIXEL_BITS];
  assign right  = rdata_b[PIXEL_BITS-1:0];

  // left neighbour is the centre of the column just passed
  always_ff @(posedge clk) begin
    if (accept) begin
      left <= centre;
    end
  end

  // strict maximum over the four neighbours
  assign hit       = interior && (centre > upper) && (centre > pixel)
                     && (centre > left) && (centre > right);
  assign res_valid = accept && hit;

  // output register and skid register
  assign out_free    = !peak_valid || !peak_stall;
  assign pixel_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      peak_valid <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        peak_value <= skid_value;
        peak_row   <= skid_row;
        peak_col   <= skid_col;
      end else begin
        peak_value <= centre;
        peak_row   <= row_count - ROW_W'(1);
        peak_col   <= col_count;
      end
    end else if (res_valid) begin
      skid_value <= centre;
      skid_row   <= row_count - ROW_W'(1);
      skid_col   <= col_count;
    end
  end

`ifndef SYNTHESIS
  // the skid register is only used behind a full output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> peak_valid)
    else $error("skid register occupied with empty output register");

  // a held skid word is not lost while the receiver keeps stalling
  assert property (@(posedge clk) disable iff (rst)
                   (skid_valid && peak_stall) |=> (skid_valid && peak_valid))
    else $error("skid word dropped under stall");

  // a peak is never on the frame border
  assert property (@(posedge clk) disable iff (rst)
                   peak_valid |-> ((peak_col != '0) && (peak_row != '0)))
    else $error("peak reported on frame border");

  // the last pixel of a row brings the column counter back to zero
  assert property (@(posedge clk) disable iff (rst)
                   (accept && last_col) |=> (col_count == '0))
    else $error("column counter failed to wrap");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-neighbour local maximum detector. It
// streams frames of pixels in raster order under several frame sizes,
// predicts every peak with its own line-store model and compares each peak
// word field by field, with random pixel gaps and random receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import lmd_pkg::*;

  localparam int MAXW     = DEF_MAX_WIDTH;
  localparam int PIXW     = DEF_PIXEL_BITS;
  localparam int COLW     = $clog2(MAXW);
  localparam int IDLE_MAX = 3000;
  localparam int HOLD_LEN = 300;

  typedef struct packed {
    logic [PIXW-1:0]  value;
    logic [ROW_W-1:0] row;
    logic [COLW-1:0]  col;
  } peak_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    EXP_NONE  = 2'd0,
    EXP_PEAK  = 2'd1,
    EXP_CHECK = 2'd2
  } exp_kind_t;

  typedef struct packed {
    logic [PIXW-1:0]  px;
    exp_kind_t        kind;
    logic [PIXW-1:0]  value;
    logic [ROW_W-1:0] row;
    logic [COLW-1:0]  col;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  cfg_index_t         cfg_index = CFG_FRAME_ROWS;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic [PIXW-1:0]    pixel = '0;
  logic               pixel_valid = 1'b0;
  logic               pixel_stall;
  logic [PIXW-1:0]    peak_value;
  logic [ROW_W-1:0]   peak_row;
  logic [COLW-1:0]    peak_col;
  logic               peak_valid;
  logic               peak_stall = 1'b0;

  local_maximum_detector_unit #(
    .MAX_WIDTH (MAXW),
    .PIXEL_BITS(PIXW)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .peak_value (peak_value),
    .peak_row   (peak_row),
    .peak_col   (peak_col),
    .peak_valid (peak_valid),
    .peak_stall (peak_stall)
  );

  always #5 clk = ~clk;

  // predictor state: frame size, line stores and raster position
  logic [ROWS_W-1:0] rows_reg = ROWS_RESET;
  logic [COLS_W-1:0] cols_reg = COLS_RESET;
  logic [PIXW-1:0]   above_row  [MAXW];
  logic [PIXW-1:0]   centre_row [MAXW];
  int unsigned       row_pos = 0;
  int unsigned       col_pos = 0;

  peak_t       pending_peaks[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned pixels_taken = 0;
  int unsigned ordinary_pixels = 0;
  int unsigned idle_cycles = 0;
  bit          pressure_done = 1'b0;

  // directed frames, 3 by 3: lone maximum, flat frame, mixed values
  directed_row_t directed_rows [0:26] = '{
    '{16'h0000, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'h0000, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'h0000, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'h0000, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'h0000, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'h0000, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'h0000, EXP_PEAK,  16'hFFFF, 12'd1, 7'd1},
    '{16'h0000, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'hFFFF, EXP_NONE,  16'h0000, 12'd0, 7'd0},
    '{16'h0003, EXP_CHECK, 16'h0000, 12'd0, 7'd0},
    '{16'h0009, EXP_CHECK, 16'h0000, 12'd0, 7'd0},
    '{16'h0004, EXP_CHECK, 16'h0000, 12'd0, 7'd0},
    '{16'h0008, EXP_CHECK, 16'h0000, 12'd0, 7'd0},
    '{16'h000A, EXP_CHECK, 16'h0000, 12'd0, 7'd0},
    '{16'h0002, EXP_CHECK, 16'h0000, 12'd0, 7'd0},
    '{16'h0001, EXP_CHECK, 16'h0000, 12'd0, 7'd0},
    '{16'h0007, EXP_CHECK, 16'h0000, 12'd0, 7'd0},
    '{16'h0006, EXP_CHECK, 16'h0000, 12'd0, 7'd0}
  };

  // frame size as the block applies it
  function automatic int unsigned frame_height();
    if (rows_reg == 0) return 1;
    if (rows_reg > ROWS_LIMIT) return ROWS_LIMIT;
    return 32'(rows_reg);
  endfunction

  function automatic int unsigned frame_width();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAXW) return MAXW;
    return 32'(cols_reg);
  endfunction

  // advance the raster by one pixel, report a strict four-neighbour maximum
  function automatic bit raster_step(input logic [PIXW-1:0] px, output peak_t pk);
    int unsigned     r;
    int unsigned     c;
    int unsigned     width;
    logic [PIXW-1:0] mid;
    logic [PIXW-1:0] up;
    logic [PIXW-1:0] lf;
    logic [PIXW-1:0] rt;
    bit              hit;
    r     = row_pos;
    c     = col_pos;
    width = frame_width();
    hit   = 1'b0;
    pk    = '0;
    if (c < MAXW) begin
      mid = centre_row[COLW'(c)];
      up  = above_row[COLW'(c)];
      if (r >= 2 && c >= 1 && c + 2 <= width && c + 1 < MAXW) begin
        // left neighbour has already moved into the upper store
        lf = above_row[COLW'(c - 1)];
        rt = centre_row[COLW'(c + 1)];
        if (mid > up && mid > px && mid > lf && mid > rt) begin
          hit      = 1'b1;
          pk.value = mid;
          pk.row   = ROW_W'(r - 1);
          pk.col   = COLW'(c);
        end
      end
      above_row[COLW'(c)]  = mid;
      centre_row[COLW'(c)] = px;
    end
    if (c + 1 >= width) begin
      col_pos = 0;
      row_pos = (r + 1 >= frame_height()) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  // random pixel, weighted towards extremes and ties
  function automatic logic [PIXW-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PIXW'($urandom_range(0, 3));
      default: return PIXW'($urandom);
    endcase
  endfunction

  // offer one word in bursts, wait for it to be taken, then predict
  task automatic send_pixel(input logic [PIXW-1:0] px, output bit hit, output peak_t pk);
    if (burst_left == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    burst_left  = burst_left - 1;
    pixel       <= px;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pixels_taken = pixels_taken + 1;
    hit = raster_step(px, pk);
  endtask

  task automatic feed(input logic [PIXW-1:0] px);
    bit    hit;
    peak_t pk;
    send_pixel(px, hit, pk);
    if (hit) pending_peaks.push_back(pk);
  endtask

  // whole frames of random pixels at the current size
  task automatic send_frames(input int unsigned frames);
    int unsigned count;
    count = frames * frame_height() * frame_width();
    repeat (count) feed(random_pixel());
    ordinary_pixels = ordinary_pixels + count;
  endtask

  // drain all peaks, then let the pipeline settle
  task automatic quiesce();
    pixel_valid <= 1'b0;
    burst_left = 0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both frame registers on consecutive edges
  task automatic set_frame(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_ROWS;
    cfg_data  <= rows_val;
    @(posedge clk);
    rows_reg = rows_val[ROWS_W-1:0];
    cfg_index <= CFG_FRAME_COLS;
    cfg_data  <= cols_val;
    @(posedge clk);
    cols_reg = cols_val[COLS_W-1:0];
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    bit    hit;
    peak_t pk;
    peak_t typed;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one frame at the reset size of 8 by 8
    send_frames(1);
    quiesce();

    // directed frames
    set_frame(CFG_W'(3), CFG_W'(3));
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, hit, pk);
      case (directed_rows[i].kind)
        EXP_PEAK: begin
          typed.value = directed_rows[i].value;
          typed.row   = directed_rows[i].row;
          typed.col   = directed_rows[i].col;
          pending_peaks.push_back(typed);
        end
        EXP_CHECK: begin
          if (hit) pending_peaks.push_back(pk);
        end
        default: ;
      endcase
    end
    ordinary_pixels = 0;
    quiesce();

    // full width, with out-of-range width clamped
    set_frame(CFG_W'(4), 13'h1FFF);
    send_frames(1);
    quiesce();
    // zero height acts as one row
    set_frame(CFG_W'(0), CFG_W'(5));
    send_frames(4);
    quiesce();
    // zero width acts as one column
    set_frame(CFG_W'(2), CFG_W'(0));
    send_frames(5);
    quiesce();
    // frames too small to have an interior
    set_frame(CFG_W'(2), CFG_W'(9));
    send_frames(2);
    quiesce();
    set_frame(CFG_W'(7), CFG_W'(2));
    send_frames(2);
    quiesce();

    // random frame sizes, mostly small
    while (ordinary_pixels < 1750) begin
      if ($urandom_range(0, 5) == 0)
        set_frame(CFG_W'($urandom_range(1, 3)), CFG_W'($urandom_range(1, 4)));
      else
        set_frame(CFG_W'($urandom_range(3, 10)), CFG_W'($urandom_range(3, 16)));
      send_frames($urandom_range(1, 3));
      quiesce();
    end

    // out-of-range height clamps to the row limit
    set_frame(13'h1FFF, CFG_W'(3));
    repeat (9) feed(random_pixel());

    pixel_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin
    int unsigned mode;
    int unsigned len;
    forever begin
      if (!pressure_done && pixels_taken >= 500) begin
        pressure_done = 1'b1;
        repeat (HOLD_LEN) begin
          @(posedge clk);
          peak_stall <= 1'b1;
        end
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 60);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0:       peak_stall <= 1'b0;
          1:       peak_stall <= ($urandom_range(0, 3) == 0);
          2:       peak_stall <= 1'($urandom_range(0, 1));
          default: peak_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // compare each taken peak word with the oldest prediction
  always @(posedge clk) begin
    peak_t want;
    if (!rst && peak_valid && !peak_stall) begin
      if (pending_peaks.size() == 0) begin
        $display("%0t: unexpected peak word: expected none, got value %h row %0d col %0d",
                 $time, peak_value, peak_row, peak_col);
        mismatches = mismatches + 1;
      end else begin
        want = pending_peaks.pop_front();
        if (peak_value !== want.value) begin
          $display("%0t: peak_value expected %h got %h", $time, want.value, peak_value);
          mismatches = mismatches + 1;
        end
        if (peak_row !== want.row) begin
          $display("%0t: peak_row expected %0d got %0d", $time, want.row, peak_row);
          mismatches = mismatches + 1;
        end
        if (peak_col !== want.col) begin
          $display("%0t: peak_col expected %0d got %0d", $time, want.col, peak_col);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // watchdog on cycles with no word taken on either channel
  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (peak_valid && !peak_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("%0t: no progress for %0d cycles, %0d peaks outstanding",
               $time, idle_cycles, pending_peaks.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/lmd_pkg.sv
hw/rtl/lmd_line_store.sv
hw/rtl/local_maximum_detector_unit.sv
dv/tb.sv
